// ===== design/bht_pkg.sv =====
// ----------------------------------------------------------------------------
// bht_pkg: shared types and constants of the block hole tracker
// Item structs, operation and status codes, and table sizing defaults.
// ----------------------------------------------------------------------------
`default_nettype none
package bht_pkg;

  localparam int unsigned MaxHolesDefault = 16;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_LAST   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_NOROOM   = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] block_num;
    logic [15:0] end_block;
    logic        completed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] next_block;
    logic        list_empty;
    logic [47:0] total_blocks;
  } out_item_t;

  // One table entry.
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] fin;
    logic [15:0] bound;
    logic [31:0] round;
  } hole_t;

endpackage
`default_nettype wire

// ===== design/block_hole_tracker.sv =====
// ----------------------------------------------------------------------------
// block_hole_tracker: sorted table of missing block ranges
// Sequencer over a register table of holes with one shift-add multiplier.
// ----------------------------------------------------------------------------
// Usage: one item on in_ carries an operation (init, set last, remove, query)
// and its block numbers. Each accepted item yields exactly one result item on
// out_ with a status, the next wanted block, an empty flag and, for a remove
// that consumes a hole start, the running block total.
// Sequence: a scan visits one table entry per cycle, then moves entries one
// per cycle when a hole is dropped or split, and a consumed start runs the
// shift-add multiplier before the entry is advanced.
// The block takes one item at a time: in_stall is high from acceptance
// until the result has been loaded into the output register.
// The output register holds the result while out_stall is high; the next
// item is accepted meanwhile, but its result waits for the register to free.
// Reset clears the hole count, the state and the output valid flag; table
// contents are left as they are and are only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none
module block_hole_tracker #(
  parameter int unsigned MAX_HOLES = bht_pkg::MaxHolesDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bht_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bht_pkg::out_item_t       out_data
);
  import bht_pkg::*;

  localparam int unsigned IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int unsigned CW = $clog2(MAX_HOLES + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_LAST  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_DROP  = 8'b0001_0000,
    S_SPLIT = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t      st_r, st_nxt;
  hole_t       tbl_r [MAX_HOLES];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;   // scan / move index
  logic [IW-1:0] hit_r, hit_nxt;   // entry being worked on
  in_item_t    req_r;
  logic [1:0]  stat_r, stat_nxt;
  logic [47:0] tot_r, tot_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   ob_r;
  logic        mul_go;

  // Table write port: one entry per cycle.
  logic        we;
  logic [IW-1:0] wa;
  hole_t       wd;

  hole_t       cur;
  hole_t       hit_e;
  logic [47:0] prod;
  logic        mul_done;

  assign cur   = tbl_r[idx_r[IW-1:0]];
  assign hit_e = tbl_r[hit_r];

  // The multiplier is started from the scan, where the matching entry is cur.
  bht_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_go),
    .mcand  (cur.round),
    .mplier ({1'b0, cur.bound} + 17'd1),
    .done   (mul_done),
    .prod   (prod)
  );

  logic [16:0] inc;
  hole_t       adv;
  assign inc = {1'b0, req_r.block_num} + 17'd1;

  always_comb begin
    adv = hit_e;
    if (inc > {1'b0, hit_e.bound}) begin
      adv.start = '0;
      if (hit_e.round != 32'hFFFF_FFFF) adv.round = hit_e.round + 32'd1;
    end else begin
      adv.start = inc[15:0];
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    hit_nxt  = hit_r;
    stat_nxt = stat_r;
    tot_nxt  = tot_r;
    ov_nxt   = ov_r;
    mul_go   = 1'b0;
    we       = 1'b0;
    wa       = '0;
    wd       = cur;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          stat_nxt = ST_OK;
          tot_nxt  = '0;
          idx_nxt  = '0;
          unique case (op_t'(in_data.op))
            OP_INIT: begin
              we       = 1'b1;
              wa       = '0;
              wd.start = in_data.block_num;
              wd.fin   = in_data.end_block;
              wd.bound = in_data.end_block;
              wd.round = '0;
              cnt_nxt  = CW'(1);
              st_nxt   = S_DONE;
            end
            OP_LAST:   st_nxt = S_LAST;
            OP_REMOVE: st_nxt = S_SCAN;
            default:   st_nxt = S_DONE;
          endcase
        end
      end
      S_LAST: begin
        if (cnt_r == '0) begin
          st_nxt = S_DONE;
        end else begin
          wa = IW'(cnt_r - CW'(1));
          wd = tbl_r[wa];
          if (wd.start > req_r.block_num) begin
            cnt_nxt = cnt_r - CW'(1);
          end else begin
            if (wd.fin > req_r.block_num) begin
              wd.fin = req_r.block_num;
              we     = 1'b1;
            end
            st_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (idx_r >= cnt_r) begin
          stat_nxt = ST_NOTFOUND;
          st_nxt   = S_DONE;
        end else if (cur.fin < req_r.block_num) begin
          idx_nxt = idx_r + CW'(1);
        end else if (cur.start > req_r.block_num) begin
          stat_nxt = ST_NOTFOUND;
          st_nxt   = S_DONE;
        end else if (cur.start == req_r.block_num) begin
          hit_nxt = idx_r[IW-1:0];
          mul_go  = 1'b1;
          st_nxt  = S_MUL;
        end else if (cur.fin == req_r.block_num) begin
          we     = 1'b1;
          wa     = idx_r[IW-1:0];
          wd.fin = req_r.block_num - 16'd1;
          st_nxt = S_DONE;
        end else if (cnt_r >= CW'(MAX_HOLES)) begin
          stat_nxt = ST_NOROOM;
          st_nxt   = S_DONE;
        end else begin
          hit_nxt = idx_r[IW-1:0];
          idx_nxt = cnt_r;       // shift from the tail down
          st_nxt  = S_SPLIT;
        end
      end
      S_MUL: begin
        // mul_go was pulsed in the scan; the multiplier runs until mul_done.
        if (mul_done) begin
          tot_nxt = {32'd0, req_r.block_num} + prod;
          we      = 1'b1;
          wa      = hit_r;
          wd      = adv;
          if (adv.start > adv.fin || req_r.completed) begin
            idx_nxt = CW'(hit_r) + CW'(1);
            st_nxt  = S_DROP;
          end else begin
            st_nxt = S_DONE;
          end
        end
      end
      S_DROP: begin
        if (idx_r >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          st_nxt  = S_DONE;
        end else begin
          we      = 1'b1;
          wa      = IW'(idx_r - CW'(1));
          wd      = cur;
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_SPLIT: begin
        if (idx_r > CW'(hit_r) + CW'(1)) begin
          we      = 1'b1;
          wa      = idx_r[IW-1:0];
          wd      = tbl_r[IW'(idx_r - CW'(1))];
          idx_nxt = idx_r - CW'(1);
        end else if (idx_r == CW'(hit_r) + CW'(1)) begin
          we       = 1'b1;
          wa       = idx_r[IW-1:0];
          wd.start = req_r.block_num + 16'd1;
          wd.fin   = hit_e.fin;
          wd.bound = hit_e.fin;
          wd.round = '0;
          idx_nxt  = '0;   // marks the upper half written
        end else begin
          we      = 1'b1;
          wa      = hit_r;
          wd      = hit_e;
          wd.fin  = req_r.block_num - 16'd1;
          cnt_nxt = cnt_r + CW'(1);
          st_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) st_nxt = S_OUT;
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (ov_r && !out_stall && st_r != S_OUT) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
    idx_r  <= idx_nxt;
    hit_r  <= hit_nxt;
    stat_r <= stat_nxt;
    tot_r  <= tot_nxt;
    if (st_r == S_IDLE && in_valid) req_r <= in_data;
    if (we) tbl_r[wa] <= wd;
    if (st_r == S_OUT) begin
      ob_r.status       <= stat_r;
      ob_r.next_block   <= (cnt_r != '0) ? tbl_r[0].start : 16'd0;
      ob_r.list_empty   <= (cnt_r == '0);
      ob_r.total_blocks <= tot_r;
    end
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = ob_r;
endmodule
`default_nettype wire

// ===== design/bht_mul.sv =====
// ----------------------------------------------------------------------------
// bht_mul: shift-add multiplier
// Forms round * (bound + 1) one bit of the 17-bit multiplier per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bht_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] mcand,
  input  wire logic [16:0] mplier,
  output logic             done,
  output logic [47:0]      prod
);
  logic [47:0] acc_r, acc_nxt;
  logic [47:0] sh_r, sh_nxt;
  logic [16:0] mp_r, mp_nxt;
  logic        busy_r, busy_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    mp_nxt   = mp_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt  = '0;
      sh_nxt   = {16'd0, mcand};
      mp_nxt   = mplier;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) acc_nxt = acc_r + sh_r;
      sh_nxt = {sh_r[46:0], 1'b0};
      mp_nxt = {1'b0, mp_r[16:1]};
      if (mp_r[16:1] == '0) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    mp_r  <= mp_nxt;
  end

  assign done = !busy_r && !start;
  assign prod = acc_r;
endmodule
`default_nettype wire
